[hw/rtl/servo_slew_rate_limiter_defines.svh]
// ----------------------------------------------------------------------------
// servo_slew_rate_limiter_defines
// assertion macros for the servo slew rate limiter
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_RATE_LIMITER_DEFINES_SVH
`define SERVO_SLEW_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SSRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SSRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ssrl_pkg.sv]
// ----------------------------------------------------------------------------
// ssrl_pkg
// shared constants and types of the servo slew rate limiter
// ----------------------------------------------------------------------------
package ssrl_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ELAPSED_W      = 16;
  localparam int CFG_IDX_W      = 3;

  localparam int RST_CMD_MIN  = -127;
  localparam int RST_CMD_MAX  = 127;
  localparam int RST_PHYS_MIN = -3840;
  localparam int RST_PHYS_MAX = 3840;
  localparam int RST_SLEW     = 19200;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CMD_MIN  = 3'd0,
    CFG_CMD_MAX  = 3'd1,
    CFG_PHYS_MIN = 3'd2,
    CFG_PHYS_MAX = 3'd3,
    CFG_SLEW     = 3'd4
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLAMP = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_TGT   = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/servo_slew_rate_limiter.sv]
// ----------------------------------------------------------------------------
// servo_slew_rate_limiter: clamps commands, maps them to a target, slews position
// an accepted word passes the clamp, prep, mul, div, tgt and upd states in turn;
// the next word waits until upd loads the output; a stalled receiver holds upd
// reset: synchronous rst_n loads default ranges, zeroes command and position
// ----------------------------------------------------------------------------
`include "servo_slew_rate_limiter_defines.svh"

module servo_slew_rate_limiter import ssrl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // command, elapsed
  input  logic [((DATA_WIDTH+ELAPSED_W+7)/8)*8-1:0]  in_tdata,
  // func
  input  logic                                       in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // position, held_command, at_target
  output logic [((2*DATA_WIDTH+1+7)/8)*8-1:0]        out_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]                       cfg_index,
  input  logic [DATA_WIDTH-1:0]                      cfg_data
);

  localparam int W           = DATA_WIDTH;
  localparam int OUT_TDATA_W = ((2*W+1+7)/8)*8;
  localparam int MAG_W       = W + 1;
  localparam int Q_W         = 2*W + 1;
  localparam int MOP_W       = (MAG_W > ELAPSED_W) ? MAG_W : ELAPSED_W;
  localparam int PROD_W      = 2*MOP_W;
  localparam int T_W         = Q_W + 2;
  localparam int P_W         = W + 2;

  state_t                   state_r;
  logic                     func_r;
  logic signed [W-1:0]      cmd_in_r;
  logic [ELAPSED_W-1:0]     elapsed_r;

  logic signed [W-1:0]      cmin_r, cmax_r, pmin_r, pmax_r;
  logic [W-1:0]             slew_r;

  logic signed [W-1:0]      stored_r;
  logic signed [W-1:0]      pos_r;

  logic [MAG_W-1:0]         magd_r, magp_r, magc_r;
  logic                     neg_r;
  logic                     czero_r;
  logic signed [W-1:0]      target_r;
  logic [PROD_W-1:0]        prod_r;

  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  logic signed [MAG_W-1:0]  d_diff, p_diff, c_diff;
  logic [MOP_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [Q_W-1:0]           quot;
  logic signed [T_W-1:0]    q_s, t_sum;
  logic signed [W-1:0]      t_sat;
  logic [W-1:0]             step;
  logic signed [P_W-1:0]    pos_e, tgt_e, pos_up, pos_dn;
  logic signed [W-1:0]      pos_nxt;
  logic                     upd_fire;
  logic                     in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // signed range differences
  always_comb begin
    d_diff = MAG_W'(stored_r) - MAG_W'(cmin_r);
    p_diff = MAG_W'(pmax_r) - MAG_W'(pmin_r);
    c_diff = MAG_W'(cmax_r) - MAG_W'(cmin_r);
  end

  // shared multiplier
  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = MOP_W'(magd_r);
      mul_b = MOP_W'(magp_r);
    end else begin
      mul_a = MOP_W'(elapsed_r);
      mul_b = MOP_W'(slew_r);
    end
    mul_p = mul_a * mul_b;
  end

  assign div_start = (state_r == S_MUL);

  ssrl_div #(
    .NUM_W (Q_W),
    .DEN_W (MAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[Q_W-1:0]),
    .divisor  (magc_r),
    .stat     (div_stat),
    .quotient (quot)
  );

  // target with saturation
  always_comb begin
    q_s   = T_W'(quot);
    t_sum = T_W'(pmin_r) + (neg_r ? -q_s : q_s);
    if (t_sum[T_W-1:W-1] == {(T_W-W+1){t_sum[T_W-1]}}) begin
      t_sat = t_sum[W-1:0];
    end else if (t_sum[T_W-1]) begin
      t_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      t_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  // slew step toward target on a tick; a write holds the position
  always_comb begin
    step   = prod_r[ELAPSED_W +: W];
    pos_e  = P_W'(pos_r);
    tgt_e  = P_W'(target_r);
    pos_up = pos_e + P_W'(step);
    pos_dn = pos_e - P_W'(step);
    pos_nxt = pos_r;
    if (func_r == FUNC_TICK) begin
      priority if (pos_r < target_r) begin
        pos_nxt = (pos_up > tgt_e) ? target_r : pos_up[W-1:0];
      end else if (pos_r > target_r) begin
        pos_nxt = (pos_dn < tgt_e) ? target_r : pos_dn[W-1:0];
      end else begin
        pos_nxt = pos_r;
      end
    end
  end

  assign upd_fire = (state_r == S_UPD) && (!out_tvalid_r || out_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (in_fire) state_r <= S_CLAMP;
        S_CLAMP: state_r <= S_PREP;
        S_PREP:  state_r <= S_MUL;
        S_MUL:   state_r <= S_DIV;
        S_DIV:   if (div_stat.done) state_r <= S_TGT;
        S_TGT:   state_r <= S_UPD;
        S_UPD:   if (upd_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmin_r <= W'(RST_CMD_MIN);
      cmax_r <= W'(RST_CMD_MAX);
      pmin_r <= W'(RST_PHYS_MIN);
      pmax_r <= W'(RST_PHYS_MAX);
      slew_r <= W'(RST_SLEW);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CMD_MIN:  cmin_r <= cfg_data;
        CFG_CMD_MAX:  cmax_r <= cfg_data;
        CFG_PHYS_MIN: pmin_r <= cfg_data;
        CFG_PHYS_MAX: pmax_r <= cfg_data;
        CFG_SLEW:     slew_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      pos_r    <= '0;
    end else begin
      if (state_r == S_CLAMP && func_r == FUNC_WRITE) begin
        priority if (cmd_in_r > cmax_r) begin
          stored_r <= cmax_r;
        end else if (cmd_in_r < cmin_r) begin
          stored_r <= cmin_r;
        end else begin
          stored_r <= cmd_in_r;
        end
      end
      if (upd_fire) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= in_tuser;
      cmd_in_r  <= in_tdata[W-1:0];
      elapsed_r <= in_tdata[W +: ELAPSED_W];
    end
    if (state_r == S_PREP) begin
      magd_r  <= d_diff[MAG_W-1] ? MAG_W'(-d_diff) : MAG_W'(d_diff);
      magp_r  <= p_diff[MAG_W-1] ? MAG_W'(-p_diff) : MAG_W'(p_diff);
      magc_r  <= c_diff[MAG_W-1] ? MAG_W'(-c_diff) : MAG_W'(c_diff);
      neg_r   <= d_diff[MAG_W-1] ^ p_diff[MAG_W-1] ^ c_diff[MAG_W-1];
      czero_r <= (c_diff == '0);
    end
    if (state_r == S_TGT) begin
      target_r <= czero_r ? pmin_r : t_sat;
      prod_r   <= mul_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (upd_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_tdata_r <= OUT_TDATA_W'({(pos_nxt == target_r), stored_r, pos_nxt});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `SSRL_ASSERT_IMPL(a_stored_in_range, (state_r == S_PREP && func_r == FUNC_WRITE && cmin_r <= cmax_r), (stored_r >= cmin_r && stored_r <= cmax_r), "stored command outside command range")
  `SSRL_ASSERT_NEXT(a_write_holds_pos, (upd_fire && func_r == FUNC_WRITE), (out_tdata[W-1:0] == $past(pos_r)), "write word moved the position")
  `SSRL_ASSERT_IMPL(a_div_done_in_div, (div_stat.done), (state_r == S_DIV), "divider finished outside divide state")

endmodule

[hw/rtl/ssrl_div.sv]
// ----------------------------------------------------------------------------
// ssrl_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssrl_div import ssrl_pkg::*; #(
  parameter int NUM_W = 2 * DATA_WIDTH_DEF + 1,
  parameter int DEN_W = DATA_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] dq_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem_r, dq_r[NUM_W-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      dq_r  <= {dq_r[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: servo slew rate limiter
// streams command writes and time ticks through the block under bursty input and
// a stalling receiver. an in-bench servo model predicts position, held command
// and at-target for every accepted word and checks each result in order. the
// ranges and the slew rate are reprogrammed between phases: defaults, full-scale,
// zero and inverted ranges, zero slew, a range change after a write, random sets
// ----------------------------------------------------------------------------
module testbench import ssrl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DATA_WIDTH_DEF;
  localparam int IN_TW = ((W + ELAPSED_W + 7) / 8) * 8;
  localparam int OUT_TW = ((2 * W + 1 + 7) / 8) * 8;
  localparam longint VMAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam int SETTLE = 2 * W + 8;
  localparam int HOLD_CYCLES = 700;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic                 func;
    logic [W-1:0]         command;
    logic [ELAPSED_W-1:0] elapsed;
  } servo_item_t;

  typedef struct packed {
    logic [W-1:0] position;
    logic [W-1:0] held;
    logic         at_target;
  } servo_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [W-1:0]      cfg_data = '0;

  servo_slew_rate_limiter #(.DATA_WIDTH(W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // servo model state
  logic signed [W-1:0] cmd_lo = W'(RST_CMD_MIN);
  logic signed [W-1:0] cmd_hi = W'(RST_CMD_MAX);
  logic signed [W-1:0] phys_lo = W'(RST_PHYS_MIN);
  logic signed [W-1:0] phys_hi = W'(RST_PHYS_MAX);
  logic [W-1:0]        slew_rate = W'(RST_SLEW);
  longint              held_cmd = 0;
  longint              servo_pos = 0;

  servo_item_t   cmd_backlog[$];
  servo_result_t predicted_out[$];
  int            in_offered = 0;
  int            in_accepted = 0;
  int            errors = 0;
  int            hold_req = 0;
  int            hold_done = 0;
  int            stall_cycles = 0;

  function automatic longint aim_point();
    longint lo, hi, plo, phi, span, t;
    lo = cmd_lo;
    hi = cmd_hi;
    plo = phys_lo;
    phi = phys_hi;
    span = hi - lo;
    if (span == 0) return plo;
    t = plo + ((held_cmd - lo) * (phi - plo)) / span;
    if (t > VMAX) t = VMAX;
    if (t < VMIN) t = VMIN;
    return t;
  endfunction

  function automatic servo_result_t servo_track(servo_item_t it);
    servo_result_t r;
    longint n, aim, stride;
    if (it.func == FUNC_WRITE) begin
      n = $signed(it.command);
      if (n > cmd_hi) n = cmd_hi;
      else if (n < cmd_lo) n = cmd_lo;
      held_cmd = n;
      aim = aim_point();
    end else begin
      stride = (longint'(it.elapsed) * longint'(slew_rate)) >>> 16;
      aim = aim_point();
      if (servo_pos < aim) begin
        servo_pos += stride;
        if (servo_pos > aim) servo_pos = aim;
      end else if (servo_pos > aim) begin
        servo_pos -= stride;
        if (servo_pos < aim) servo_pos = aim;
      end
    end
    r.position = servo_pos[W-1:0];
    r.held = held_cmd[W-1:0];
    r.at_target = (servo_pos == aim);
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 1;
  int send_gap = 0;

  always @(negedge clk) begin : drive
    servo_item_t nx;
    if (in_tvalid && in_accepted != in_offered) begin
      // word still on offer
    end else if (send_gap > 0) begin
      send_gap--;
      in_tvalid <= 1'b0;
    end else if (rst_n && cmd_backlog.size() > 0) begin
      nx = cmd_backlog.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= nx.func;
      in_tdata <= IN_TW'({nx.elapsed, nx.command});
      in_offered++;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 8);
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver: runs of ready and stall, plus a long hold-off on request
  int hold_cnt = 0;
  int rx_run = 0;
  bit rx_level = 1'b1;

  always @(negedge clk) begin : receive
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_level = ($urandom_range(0, 2) != 0);
        rx_run = $urandom_range(1, 50);
      end
      rx_run--;
      out_tready <= rx_level ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // scoreboard
  always @(posedge clk) begin : scoreboard
    servo_item_t it;
    servo_result_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CMD_MIN:  cmd_lo = cfg_data;
          CFG_CMD_MAX:  cmd_hi = cfg_data;
          CFG_PHYS_MIN: phys_lo = cfg_data;
          CFG_PHYS_MAX: phys_hi = cfg_data;
          CFG_SLEW:     slew_rate = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it.func = in_tuser;
        it.command = in_tdata[W-1:0];
        it.elapsed = in_tdata[W +: ELAPSED_W];
        predicted_out.push_back(servo_track(it));
        in_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.position = out_tdata[W-1:0];
        got.held = out_tdata[W +: W];
        got.at_target = out_tdata[2*W];
        if (predicted_out.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, got %h", $time, out_tdata);
        end else begin
          want = predicted_out.pop_front();
          if (got.position !== want.position) begin
            errors++;
            $display("%0t position: expected %h, got %h", $time, want.position,
                     got.position);
          end
          if (got.held !== want.held) begin
            errors++;
            $display("%0t held_command: expected %h, got %h", $time, want.held, got.held);
          end
          if (got.at_target !== want.at_target) begin
            errors++;
            $display("%0t at_target: expected %b, got %b", $time, want.at_target,
                     got.at_target);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL servo_slew_rate_limiter");
      $finish;
    end
  end

  // stimulus
  task automatic add_write(longint cmd);
    servo_item_t it;
    it.func = FUNC_WRITE;
    it.command = W'(cmd);
    it.elapsed = ELAPSED_W'($urandom);
    cmd_backlog.push_back(it);
  endtask

  task automatic add_tick(longint dt);
    servo_item_t it;
    it.func = FUNC_TICK;
    it.command = W'($urandom);
    it.elapsed = ELAPSED_W'(dt);
    cmd_backlog.push_back(it);
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || in_accepted != in_offered ||
           predicted_out.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(cfg_idx_t idx, longint v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(longint lo, longint hi, longint plo, longint phi, longint rate);
    settle();
    reg_write(CFG_CMD_MIN, lo);
    reg_write(CFG_CMD_MAX, hi);
    reg_write(CFG_PHYS_MIN, plo);
    reg_write(CFG_PHYS_MAX, phi);
    reg_write(CFG_SLEW, rate);
  endtask

  function automatic longint pick_command();
    longint lo, hi, t;
    lo = cmd_lo;
    hi = cmd_hi;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(0, 3))
      0: return longint'($urandom);
      1: return (($urandom_range(0, 1) != 0) ? hi : lo) + $urandom_range(0, 2) - 1;
      default: return lo + longint'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  function automatic longint pick_elapsed();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2, 3, 4, 5: return $urandom_range(0, 2000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic longint pick_reg(longint lo, longint hi);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return hi;
      default: return lo + longint'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  // mostly a write followed by a few ticks, some raw noise
  task automatic random_run(int n);
    int made, k;
    servo_item_t it;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        it = servo_item_t'({$urandom, $urandom});
        cmd_backlog.push_back(it);
        made++;
      end else begin
        add_write(pick_command());
        k = $urandom_range(1, 6);
        repeat (k) add_tick(pick_elapsed());
        made += k + 1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset ranges
    add_tick(0);
    add_write(127);
    add_tick(65535);
    add_write(200);
    add_write(-32768);
    add_tick(1);
    add_tick(65535);
    add_tick(65535);
    add_write(32767);
    add_tick(0);
    add_tick(100);
    add_write(0);
    add_tick(65535);
    add_write(-1);
    add_tick(3);
    add_write(1);
    add_tick(65535);
    add_write(-127);
    add_write(-128);
    add_tick(65535);
    add_tick(65535);

    // reset values written back, receiver held off while input keeps coming
    apply_cfg(RST_CMD_MIN, RST_CMD_MAX, RST_PHYS_MIN, RST_PHYS_MAX, RST_SLEW);
    random_run(160);
    hold_req++;

    apply_cfg(VMIN, VMAX, VMIN, VMAX, 65535);
    random_run(160);

    // zero command range
    apply_cfg(5, 5, -1000, 2000, 300);
    random_run(100);

    // inverted ranges
    apply_cfg(100, -100, 1000, -1000, 5000);
    random_run(120);
    apply_cfg(VMAX, VMIN, VMAX, VMIN, 1);
    random_run(100);

    // zero slew
    apply_cfg(RST_CMD_MIN, RST_CMD_MAX, RST_PHYS_MIN, RST_PHYS_MAX, 0);
    random_run(60);

    // range narrowed after a write: target saturates
    apply_cfg(VMIN, VMAX, VMIN, VMAX, 65535);
    add_write(30000);
    add_tick(65535);
    apply_cfg(0, 1, 0, VMAX, 65535);
    repeat (3) add_tick(65535);
    add_tick(0);
    apply_cfg(VMIN, VMAX, VMIN, VMAX, 65535);
    add_write(-30000);
    add_tick(65535);
    apply_cfg(0, 1, 0, VMAX, 65535);
    repeat (3) add_tick(65535);
    add_write(7);

    repeat (8) begin
      apply_cfg(pick_reg(VMIN, VMAX), pick_reg(VMIN, VMAX), pick_reg(VMIN, VMAX),
                pick_reg(VMIN, VMAX), pick_reg(0, 65535));
      random_run(80);
    end

    settle();
    if (errors == 0)
      $display("PASS servo_slew_rate_limiter");
    else
      $display("FAIL servo_slew_rate_limiter");
    $finish;
  end

endmodule
